/* rtl/vfc_pkg.sv */
// Shared types and constants of the vertical column filter.
package vfc_pkg;

    // Fixed field widths of the register file and the result
    localparam int TAP_REGS      = 5;
    localparam int TAP_BITS      = 16;
    localparam int TC_BITS       = 3;
    localparam int WIDTH_BITS    = 11;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;
    localparam int OUT_BITS      = 34;
    localparam int OUT_TDATA_W   = ((OUT_BITS + 7) / 8) * 8;

    // Register indexes of the configuration port
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_TAP_ZERO  = 3'd0,
        CFG_TAP_ONE   = 3'd1,
        CFG_TAP_TWO   = 3'd2,
        CFG_TAP_THREE = 3'd3,
        CFG_TAP_FOUR  = 3'd4,
        CFG_TAP_COUNT = 3'd5,
        CFG_ROW_WIDTH = 3'd6,
        CFG_OUT_WIDTH = 3'd7
    } t_cfg_index;

    // Register reset values
    localparam logic [TAP_BITS-1:0]   TAP_ZERO_RESET  = 16'd16384;
    localparam logic [TC_BITS-1:0]    TAP_COUNT_RESET = 3'd1;
    localparam logic [WIDTH_BITS-1:0] ROW_WIDTH_RESET = 11'd1024;
    localparam logic [WIDTH_BITS-1:0] OUT_WIDTH_RESET = 11'd1024;

    // Configuration register file as seen by the datapath
    typedef struct packed {
        logic [TAP_REGS-1:0][TAP_BITS-1:0] taps;
        logic [TC_BITS-1:0]                tap_count;
        logic [WIDTH_BITS-1:0]             row_width;
        logic [WIDTH_BITS-1:0]             out_width;
    } t_cfg;

    // Side flags that travel with a result
    typedef struct packed {
        logic row_end;
        logic frame_done;
    } t_flags;

endpackage

/* rtl/vfc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module vfc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write and read ports; a read at the same address returns the old word
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/vfc_window.sv */
// Row and column counters, line store and tap operand selection.
module vfc_window #(
    parameter int MAX_TAPS      = 5,
    parameter int MAX_ROW_WIDTH = 1024,
    parameter int PIXEL_BITS    = 16,
    localparam int NTAPS = (MAX_TAPS < vfc_pkg::TAP_REGS) ? MAX_TAPS : vfc_pkg::TAP_REGS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  vfc_pkg::t_cfg                      i_cfg,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [PIXEL_BITS-1:0]              i_pixel,
    input  logic                               i_frame_end,
    output logic                               o_op_valid,
    input  logic                               i_op_ready,
    output logic [NTAPS-1:0][PIXEL_BITS-1:0]   o_op_x,
    output vfc_pkg::t_flags                    o_op_flags
);

    localparam int LS_N   = (NTAPS > 1) ? NTAPS - 1 : 1;
    localparam int LS_W   = LS_N * PIXEL_BITS;
    localparam int COL_W  = $clog2(MAX_ROW_WIDTH);
    localparam int CNT_W  = $clog2(MAX_ROW_WIDTH + 1);
    localparam int RW_W   = (CNT_W > vfc_pkg::WIDTH_BITS) ? CNT_W : vfc_pkg::WIDTH_BITS;
    localparam int TC_W   = vfc_pkg::TC_BITS;

    typedef logic [LS_N-1:0][PIXEL_BITS-1:0] t_vec;

    // Counters
    logic [COL_W-1:0] r_col, n_col;
    logic [TC_W-1:0]  r_row, n_row;

    // Stage A: request waiting for its line store word
    logic                  r_a_valid;
    logic [PIXEL_BITS-1:0] r_a_px;
    logic [COL_W-1:0]      r_a_col;
    logic                  r_a_produce;
    vfc_pkg::t_flags       r_a_flags;
    logic                  r_fwd_hit;
    t_vec                  r_fwd_vec;

    logic [TC_W-1:0] tc_eff, tc_m1, row_cl;
    logic [RW_W-1:0] rw_eff, ow_eff, col_ext, col_inc;
    logic            last_col, produce, s_go, a_go, fwd_hit;
    t_vec            rd_vec, old_vec, new_vec;
    logic [NTAPS-1:0][PIXEL_BITS-1:0] x;

    // Effective register values
    always_comb begin
        tc_eff = i_cfg.tap_count;
        if (i_cfg.tap_count == '0) begin
            tc_eff = TC_W'(1);
        end else if (i_cfg.tap_count > TC_W'(NTAPS)) begin
            tc_eff = TC_W'(NTAPS);
        end
        tc_m1 = tc_eff - TC_W'(1);

        rw_eff = RW_W'(i_cfg.row_width);
        if (i_cfg.row_width == '0) begin
            rw_eff = RW_W'(1);
        end else if (RW_W'(i_cfg.row_width) > RW_W'(MAX_ROW_WIDTH)) begin
            rw_eff = RW_W'(MAX_ROW_WIDTH);
        end

        ow_eff = RW_W'(i_cfg.out_width);
        if (i_cfg.out_width == '0) begin
            ow_eff = RW_W'(1);
        end else if (RW_W'(i_cfg.out_width) > rw_eff) begin
            ow_eff = rw_eff;
        end
    end

    // Position of the incoming pixel and the counter update
    always_comb begin
        row_cl   = (r_row > tc_m1) ? tc_m1 : r_row;
        col_ext  = RW_W'(r_col);
        col_inc  = col_ext + RW_W'(1);
        last_col = (col_inc >= rw_eff);
        produce  = (row_cl == tc_m1) && (col_ext < ow_eff);

        n_col = r_col + COL_W'(1);
        n_row = row_cl;
        if (i_frame_end) begin
            n_col = '0;
            n_row = '0;
        end else if (last_col) begin
            n_col = '0;
            if (row_cl < tc_m1) begin
                n_row = row_cl + TC_W'(1);
            end
        end
    end

    // Handshake: stage A drains into the multiplier or drops a silent pixel
    assign a_go    = r_a_valid && (!r_a_produce || i_op_ready);
    assign o_ready = !r_a_valid || a_go;
    assign s_go    = i_valid && o_ready;
    assign fwd_hit = r_a_valid && a_go && (r_a_col == r_col);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_a_valid <= 1'b0;
        end else begin
            if (s_go) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            if (o_ready) begin
                r_a_valid <= i_valid;
            end
        end
    end

    // Capture the request and bypass the word written at the same edge
    always_ff @(posedge i_clk) begin
        if (s_go) begin
            r_a_px      <= i_pixel;
            r_a_col     <= r_col;
            r_a_produce <= produce;
            r_a_flags   <= '{row_end: (col_inc == ow_eff), frame_done: i_frame_end};
            r_fwd_hit   <= fwd_hit;
            r_fwd_vec   <= new_vec;
        end
    end

    // Line store: one word per column holds the previous rows
    vfc_ram #(
        .WIDTH (LS_W),
        .DEPTH (MAX_ROW_WIDTH)
    ) u_line_store (
        .i_clk     (i_clk),
        .i_wr_en   (a_go),
        .i_wr_addr (r_a_col),
        .i_wr_data (new_vec),
        .i_rd_en   (s_go),
        .i_rd_addr (r_col),
        .o_rd_data (rd_vec)
    );

    // Shift the column history by one row
    always_comb begin
        old_vec    = r_fwd_hit ? r_fwd_vec : rd_vec;
        new_vec    = old_vec;
        new_vec[0] = r_a_px;
        for (int d = 1; d < LS_N; d++) begin
            new_vec[d] = old_vec[d-1];
        end
    end

    // Line up each tap with its row; the newest pixel takes the last tap in use
    always_comb begin
        for (int r = 0; r < NTAPS; r++) begin
            x[r] = '0;
            if (r == int'(tc_m1)) begin
                x[r] = r_a_px;
            end else begin
                for (int d = 0; d < LS_N; d++) begin
                    if (r + d + 2 == int'(tc_eff)) begin
                        x[r] = old_vec[d];
                    end
                end
            end
        end
    end

    assign o_op_valid = r_a_valid && r_a_produce;
    assign o_op_x     = x;
    assign o_op_flags = r_a_flags;

endmodule

/* rtl/vfc_mac.sv */
// Multiply and adder tree pipeline with the output register.
module vfc_mac #(
    parameter int MAX_TAPS   = 5,
    parameter int PIXEL_BITS = 16,
    localparam int NTAPS = (MAX_TAPS < vfc_pkg::TAP_REGS) ? MAX_TAPS : vfc_pkg::TAP_REGS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  vfc_pkg::t_cfg                      i_cfg,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [NTAPS-1:0][PIXEL_BITS-1:0]   i_x,
    input  vfc_pkg::t_flags                    i_flags,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [vfc_pkg::OUT_BITS-1:0]       o_value,
    output vfc_pkg::t_flags                    o_flags
);

    localparam int NPAIR  = (NTAPS + 1) / 2;
    localparam int NPROD  = 2 * NPAIR;
    localparam int PROD_W = vfc_pkg::TAP_BITS + PIXEL_BITS;
    localparam int PSUM_W = PROD_W + 1;
    localparam int SUM_W  = PROD_W + 3;
    localparam int EXT_W  = (SUM_W > vfc_pkg::OUT_BITS) ? SUM_W : vfc_pkg::OUT_BITS;

    // Stage B: operands
    logic                                r_b_valid;
    logic [NTAPS-1:0][PIXEL_BITS-1:0]    r_b_x;
    vfc_pkg::t_flags                     r_b_flags;
    // Stage C: products
    logic                                r_c_valid;
    logic signed [PROD_W-1:0]            r_c_prod [NPROD];
    vfc_pkg::t_flags                     r_c_flags;
    // Stage D: pair sums
    logic                                r_d_valid;
    logic signed [PSUM_W-1:0]            r_d_sum [NPAIR];
    vfc_pkg::t_flags                     r_d_flags;
    // Output register
    logic                                r_o_valid;
    logic [vfc_pkg::OUT_BITS-1:0]        r_o_value;
    vfc_pkg::t_flags                     r_o_flags;

    logic signed [PROD_W-1:0] n_prod [NPROD];
    logic signed [PSUM_W-1:0] n_sum [NPAIR];
    logic signed [EXT_W-1:0]  n_value;
    logic ready_b, ready_c, ready_d, ready_o;

    // Each stage advances when the next one is free or moving
    assign ready_o = !r_o_valid || i_ready;
    assign ready_d = !r_d_valid || ready_o;
    assign ready_c = !r_c_valid || ready_d;
    assign ready_b = !r_b_valid || ready_c;
    assign o_ready = ready_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (ready_b) r_b_valid <= i_valid;
            if (ready_c) r_c_valid <= r_b_valid;
            if (ready_d) r_d_valid <= r_c_valid;
            if (ready_o) r_o_valid <= r_d_valid;
        end
    end

    // One signed multiply per tap; the padding slot stays zero
    always_comb begin
        for (int r = 0; r < NPROD; r++) begin
            n_prod[r] = '0;
        end
        for (int r = 0; r < NTAPS; r++) begin
            n_prod[r] = PROD_W'($signed(i_cfg.taps[r])) * PROD_W'($signed(r_b_x[r]));
        end
    end

    // Add neighboring products
    always_comb begin
        for (int k = 0; k < NPAIR; k++) begin
            n_sum[k] = PSUM_W'(r_c_prod[2*k]) + PSUM_W'(r_c_prod[2*k+1]);
        end
    end

    // Final sum at full precision, kept to the result width
    always_comb begin
        n_value = '0;
        for (int k = 0; k < NPAIR; k++) begin
            n_value = n_value + EXT_W'(r_d_sum[k]);
        end
    end

    // Payload registers follow their stage enables
    always_ff @(posedge i_clk) begin
        if (ready_b && i_valid) begin
            r_b_x     <= i_x;
            r_b_flags <= i_flags;
        end
        if (ready_c && r_b_valid) begin
            r_c_prod  <= n_prod;
            r_c_flags <= r_b_flags;
        end
        if (ready_d && r_c_valid) begin
            r_d_sum   <= n_sum;
            r_d_flags <= r_c_flags;
        end
        if (ready_o && r_d_valid) begin
            r_o_value <= n_value[vfc_pkg::OUT_BITS-1:0];
            r_o_flags <= r_d_flags;
        end
    end

    assign o_valid = r_o_valid;
    assign o_value = r_o_value;
    assign o_flags = r_o_flags;

endmodule

/* rtl/vertical_fir_column_filter.sv */
// Top level of the vertical column filter: register file and pipeline.
//
//  Channel     Direction  Handshake                         Payload
//  s_axis      in         i_s_axis_tvalid/o_s_axis_tready   tdata: pixel; tlast: frame end
//  m_axis      out        o_m_axis_tvalid/i_m_axis_tready   tdata: sum; tlast: row end;
//                                                           tuser: frame done
//  cfg         in         i_cfg_valid/o_cfg_ready           index, data (always ready)
//
// One pixel per cycle is taken unless a result stall reaches back to the input; a pixel
// then passes line store read, multiply, pair add, final add and output register in order.
// The line store is a single RAM read and written once per pixel, with the word
// written at the same edge bypassed, so one column repeating on back-to-back pixels still flows.
// Reset clears counters, pipeline valids and registers; the line store is not
// cleared and needs tap_count-1 rows of a frame before results appear.
// A stall at the output fills the empty stages first, then holds every stage.
module vertical_fir_column_filter #(
    parameter int MAX_TAPS      = 5,
    parameter int MAX_ROW_WIDTH = 1024,
    parameter int PIXEL_BITS    = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // pixel stream
    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    input  logic [((PIXEL_BITS + 7) / 8) * 8-1:0] i_s_axis_tdata,   // [PIXEL_BITS-1:0] pixel
    input  logic                                 i_s_axis_tlast,
    // result stream
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    output logic [vfc_pkg::OUT_TDATA_W-1:0]      o_m_axis_tdata,   // [33:0] filtered_value
    output logic                                 o_m_axis_tlast,
    output logic                                 o_m_axis_tuser,   // [0] frame_done
    // register writes
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [vfc_pkg::CFG_IDX_BITS-1:0]     i_cfg_index,
    input  logic [vfc_pkg::CFG_DATA_BITS-1:0]    i_cfg_data
);

    localparam int NTAPS = (MAX_TAPS < vfc_pkg::TAP_REGS) ? MAX_TAPS : vfc_pkg::TAP_REGS;

    vfc_pkg::t_cfg   r_cfg, n_cfg;
    logic                             op_valid, op_ready;
    logic [NTAPS-1:0][PIXEL_BITS-1:0] op_x;
    vfc_pkg::t_flags                  op_flags, out_flags;
    logic [vfc_pkg::OUT_BITS-1:0]     out_value;

    // Register file update
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (vfc_pkg::t_cfg_index'(i_cfg_index))
                vfc_pkg::CFG_TAP_ZERO:  n_cfg.taps[0]   = i_cfg_data;
                vfc_pkg::CFG_TAP_ONE:   n_cfg.taps[1]   = i_cfg_data;
                vfc_pkg::CFG_TAP_TWO:   n_cfg.taps[2]   = i_cfg_data;
                vfc_pkg::CFG_TAP_THREE: n_cfg.taps[3]   = i_cfg_data;
                vfc_pkg::CFG_TAP_FOUR:  n_cfg.taps[4]   = i_cfg_data;
                vfc_pkg::CFG_TAP_COUNT:
                    n_cfg.tap_count = i_cfg_data[vfc_pkg::TC_BITS-1:0];
                vfc_pkg::CFG_ROW_WIDTH:
                    n_cfg.row_width = i_cfg_data[vfc_pkg::WIDTH_BITS-1:0];
                vfc_pkg::CFG_OUT_WIDTH:
                    n_cfg.out_width = i_cfg_data[vfc_pkg::WIDTH_BITS-1:0];
                default: n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{
                taps:      (vfc_pkg::TAP_REGS * vfc_pkg::TAP_BITS)'(vfc_pkg::TAP_ZERO_RESET),
                tap_count: vfc_pkg::TAP_COUNT_RESET,
                row_width: vfc_pkg::ROW_WIDTH_RESET,
                out_width: vfc_pkg::OUT_WIDTH_RESET
            };
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg_ready = 1'b1;

    // Counters, line store and operand selection
    vfc_window #(
        .MAX_TAPS      (MAX_TAPS),
        .MAX_ROW_WIDTH (MAX_ROW_WIDTH),
        .PIXEL_BITS    (PIXEL_BITS)
    ) u_window (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_pixel     (i_s_axis_tdata[PIXEL_BITS-1:0]),
        .i_frame_end (i_s_axis_tlast),
        .o_op_valid  (op_valid),
        .i_op_ready  (op_ready),
        .o_op_x      (op_x),
        .o_op_flags  (op_flags)
    );

    // Multiply-accumulate pipeline
    vfc_mac #(
        .MAX_TAPS   (MAX_TAPS),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (op_valid),
        .o_ready (op_ready),
        .i_x     (op_x),
        .i_flags (op_flags),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_value (out_value),
        .o_flags (out_flags)
    );

    assign o_m_axis_tdata = vfc_pkg::OUT_TDATA_W'(out_value);
    assign o_m_axis_tlast = out_flags.row_end;
    assign o_m_axis_tuser = out_flags.frame_done;

endmodule

/* bench/tb_vertical_fir_column_filter.sv */
// Self-checking bench for the vertical column filter: pixel frames scored by a shadow filter.
`timescale 1ns / 100ps

module tb_vertical_fir_column_filter;
    import vfc_pkg::*;

    localparam int MAX_TAPS      = 5;
    localparam int MAX_ROW_WIDTH = 1024;
    localparam int PIXEL_BITS    = 16;
    localparam int PX_TDATA_W    = ((PIXEL_BITS + 7) / 8) * 8;
    localparam int CLK_PERIOD    = 10;
    localparam int RESET_CYCLES  = 12;
    localparam int SETTLE_CYCLES = 8;
    localparam int ITEM_TARGET   = 1900;
    localparam int CYCLE_LIMIT   = 400000;

    typedef struct {
        logic [PIXEL_BITS-1:0] pixel;
        logic                  frame_end;
    } t_pixel_req;

    typedef struct packed {
        logic [OUT_BITS-1:0] value;
        logic                row_end;
        logic                frame_done;
    } t_sum_result;

    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_PERIODIC, RX_SPARSE} t_rx_mode;
    typedef enum logic [1:0] {SHAPE_NOISE, SHAPE_CUT, SHAPE_OPEN, SHAPE_FULL} t_frame_shape;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_s_axis_tvalid = 1'b0;
    logic                     o_s_axis_tready;
    logic [PX_TDATA_W-1:0]    i_s_axis_tdata = '0;     // [15:0] pixel
    logic                     i_s_axis_tlast = 1'b0;   // frame end
    logic                     o_m_axis_tvalid;
    logic                     i_m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]   o_m_axis_tdata;          // [33:0] filtered_value
    logic                     o_m_axis_tlast;          // row end
    logic                     o_m_axis_tuser;          // [0] frame_done
    logic                     i_cfg_valid = 1'b0;
    logic                     o_cfg_ready;
    logic [CFG_IDX_BITS-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] i_cfg_data = '0;

    vertical_fir_column_filter #(
        .MAX_TAPS      (MAX_TAPS),
        .MAX_ROW_WIDTH (MAX_ROW_WIDTH),
        .PIXEL_BITS    (PIXEL_BITS)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Shadow filter: registers, counters and per-column history of earlier rows
    logic signed [TAP_BITS-1:0]   tap_coef [MAX_TAPS] = '{16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd0};
    logic [TC_BITS-1:0]           tap_cnt = TAP_COUNT_RESET;
    logic [WIDTH_BITS-1:0]        row_w = ROW_WIDTH_RESET;
    logic [WIDTH_BITS-1:0]        out_w = OUT_WIDTH_RESET;
    logic signed [PIXEL_BITS-1:0] col_hist [MAX_ROW_WIDTH][MAX_TAPS-1];
    int                           col_pos = 0;
    int                           row_cnt = 0;
    bit                           frame_open = 1'b0;

    t_pixel_req  pixel_requests [$];
    t_sum_result expected_sums [$];
    int          items_queued = 0;
    int          mismatch_cnt = 0;
    int          cycle_cnt = 0;
    bit          px_taken = 1'b0;

    function automatic int active_taps();
        if (tap_cnt == 0) return 1;
        if (tap_cnt > MAX_TAPS) return MAX_TAPS;
        return int'(tap_cnt);
    endfunction

    function automatic int clamp_row(input logic [WIDTH_BITS-1:0] w);
        if (w == 0) return 1;
        if (w > MAX_ROW_WIDTH) return MAX_ROW_WIDTH;
        return int'(w);
    endfunction

    function automatic int active_out_len(input int rw);
        if (out_w == 0) return 1;
        if (out_w > rw) return rw;
        return int'(out_w);
    endfunction

    // Advance the shadow filter by one accepted pixel and queue the sum it yields
    function automatic void filter_pixel(input logic signed [PIXEL_BITS-1:0] px,
                                         input logic fend);
        int          tc;
        int          rw;
        int          ow;
        int          col;
        int          r;
        bit          last_col;
        longint      acc;
        t_sum_result res;
        tc = active_taps();
        rw = clamp_row(row_w);
        ow = active_out_len(rw);
        col = col_pos;
        last_col = (col_pos + 1 >= rw);
        if (row_cnt > tc - 1) row_cnt = tc - 1;
        if (col > MAX_ROW_WIDTH - 1) col = MAX_ROW_WIDTH - 1;

        // Oldest row takes the first tap, the current pixel the last one in use
        if (row_cnt == tc - 1 && col_pos < ow) begin
            acc = longint'(tap_coef[tc-1]) * longint'(px);
            for (r = 0; r + 1 < tc; r++) begin
                acc += longint'(tap_coef[r]) * longint'(col_hist[col][tc-2-r]);
            end
            res.value      = acc[OUT_BITS-1:0];
            res.row_end    = (col_pos + 1 == ow);
            res.frame_done = fend;
            expected_sums.push_back(res);
        end

        // Shift the column history down by one row
        for (r = MAX_TAPS - 2; r > 0; r--) begin
            col_hist[col][r] = col_hist[col][r-1];
        end
        col_hist[col][0] = px;

        if (fend) begin
            col_pos = 0;
            row_cnt = 0;
        end else if (last_col) begin
            col_pos = 0;
            if (row_cnt < tc - 1) row_cnt++;
        end else begin
            col_pos++;
        end
        frame_open = !fend;
    endfunction

    function automatic void store_reg(input t_cfg_index idx, input logic [15:0] val);
        case (idx)
            CFG_TAP_COUNT: tap_cnt = val[TC_BITS-1:0];
            CFG_ROW_WIDTH: row_w = val[WIDTH_BITS-1:0];
            CFG_OUT_WIDTH: out_w = val[WIDTH_BITS-1:0];
            default: tap_coef[int'(idx)] = val;
        endcase
    endfunction

    function automatic logic [15:0] rand_pixel();
        case ($urandom_range(0, 11))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic void queue_pixel(input logic [15:0] px, input logic fend);
        t_pixel_req req;
        req.pixel     = px;
        req.frame_end = fend;
        pixel_requests.push_back(req);
        items_queued++;
    endfunction

    // Wait until every request is taken and every sum is back, then let the pipe empty
    task automatic drain();
        while (pixel_requests.size() != 0 || expected_sums.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Write the selected registers back to back, then drop the request
    task automatic program_regs(input logic [15:0] vals [8], input logic [7:0] mask);
        int i;
        for (i = 0; i < 8; i++) begin
            if (mask[i]) begin
                @(negedge i_clk);
                i_cfg_valid <= 1'b1;
                i_cfg_index <= t_cfg_index'(i);
                i_cfg_data  <= vals[i];
                @(posedge i_clk);
                while (!o_cfg_ready) @(posedge i_clk);
                store_reg(t_cfg_index'(i), vals[i]);
            end
        end
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Pixel acceptance: score the request that was on the bus, then retire it
    always @(posedge i_clk) begin
        px_taken = i_rst_n && i_s_axis_tvalid && o_s_axis_tready;
        if (px_taken) begin
            filter_pixel(i_s_axis_tdata[PIXEL_BITS-1:0], i_s_axis_tlast);
            void'(pixel_requests.pop_front());
        end
    end

    // Pixel driver: bursts of random length separated by random gaps
    int burst_left = 1;
    int idle_gap = 0;

    always @(negedge i_clk) begin
        if (i_s_axis_tvalid && !px_taken) begin
            // hold the request until it is taken
        end else if (idle_gap > 0) begin
            idle_gap        <= idle_gap - 1;
            i_s_axis_tvalid <= 1'b0;
        end else if (pixel_requests.size() == 0) begin
            i_s_axis_tvalid <= 1'b0;
        end else begin
            i_s_axis_tvalid <= 1'b1;
            i_s_axis_tdata  <= PX_TDATA_W'(pixel_requests[0].pixel);
            i_s_axis_tlast  <= pixel_requests[0].frame_end;
            if (burst_left <= 1) begin
                burst_left <= $urandom_range(1, 40);
                idle_gap   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
                burst_left <= burst_left - 1;
            end
        end
    end

    // Result receiver: stall pattern switches among a few modes
    t_rx_mode rx_mode = RX_OPEN;
    int       rx_hold = 100;

    always @(negedge i_clk) begin
        if (rx_hold == 0) begin
            rx_mode <= t_rx_mode'($urandom_range(0, 3));
            rx_hold <= $urandom_range(50, 300);
        end else begin
            rx_hold <= rx_hold - 1;
        end
        case (rx_mode)
            RX_OPEN:     i_m_axis_tready <= 1'b1;
            RX_COIN:     i_m_axis_tready <= 1'($urandom_range(0, 1));
            RX_PERIODIC: i_m_axis_tready <= (cycle_cnt % 5) < 2;
            default:     i_m_axis_tready <= ($urandom_range(0, 7) != 0);
        endcase
    end

    // Result check against the oldest expected sum
    always @(posedge i_clk) begin
        t_sum_result got;
        t_sum_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.value      = o_m_axis_tdata[OUT_BITS-1:0];
            got.row_end    = o_m_axis_tlast;
            got.frame_done = o_m_axis_tuser;
            if (expected_sums.size() == 0) begin
                $display("%0t: unexpected result, expected none, got sum %h row_end %b done %b",
                         $time, got.value, got.row_end, got.frame_done);
                mismatch_cnt++;
            end else begin
                want = expected_sums.pop_front();
                if (got.value !== want.value || got.row_end !== want.row_end ||
                    got.frame_done !== want.frame_done) begin
                    $display("%0t: expected sum %h row_end %b done %b, got sum %h row_end %b done %b",
                             $time, want.value, want.row_end, want.frame_done,
                             got.value, got.row_end, got.frame_done);
                    mismatch_cnt++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Stimulus sequence
    initial begin
        int           k;
        int           f;
        int           n_frames;
        int           rows;
        int           len;
        int           pick;
        int           cur_rw;
        t_frame_shape shape;
        logic [15:0]  reg_vals [8];
        logic [7:0]   reg_mask;
        logic [15:0]  px;

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Default registers: pixel extremes pass through the single tap
        @(posedge i_clk);
        queue_pixel(16'h7FFF, 1'b0);
        queue_pixel(16'h8000, 1'b0);
        queue_pixel(16'h0000, 1'b0);
        queue_pixel(16'hFFFF, 1'b1);
        drain();

        // Five extreme taps, narrow rows, output width above row width
        reg_vals[CFG_TAP_ZERO]  = 16'h8000;
        reg_vals[CFG_TAP_ONE]   = 16'h7FFF;
        reg_vals[CFG_TAP_TWO]   = 16'h8000;
        reg_vals[CFG_TAP_THREE] = 16'h7FFF;
        reg_vals[CFG_TAP_FOUR]  = 16'h8000;
        reg_vals[CFG_TAP_COUNT] = 16'hA5A5;
        reg_vals[CFG_ROW_WIDTH] = 16'd3;
        reg_vals[CFG_OUT_WIDTH] = 16'h07FF;
        program_regs(reg_vals, 8'hFF);

        // The first two columns alternate sign per row so their sums reach both ends of the range;
        // stop two pixels into the fifth row
        @(posedge i_clk);
        for (k = 0; k < 14; k++) begin
            if (k % 3 == 2) px = rand_pixel();
            else px = (((k / 3) % 2 == 0) ^ (k % 3 == 1)) ? 16'h8000 : 16'h7FFF;
            queue_pixel(px, 1'b0);
        end
        drain();

        // Narrow the row below the current column and drop to three taps mid-frame
        reg_mask = '0;
        reg_mask[CFG_TAP_COUNT] = 1'b1;
        reg_mask[CFG_ROW_WIDTH] = 1'b1;
        reg_vals[CFG_TAP_COUNT] = 16'hFFF3;
        reg_vals[CFG_ROW_WIDTH] = 16'd2;
        program_regs(reg_vals, reg_mask);
        @(posedge i_clk);
        queue_pixel(rand_pixel(), 1'b0);
        queue_pixel(rand_pixel(), 1'b1);
        drain();

        // Widest row with a zero tap count: every column of the counter is visited
        reg_mask = '0;
        reg_mask[CFG_TAP_ZERO]  = 1'b1;
        reg_mask[CFG_TAP_COUNT] = 1'b1;
        reg_mask[CFG_ROW_WIDTH] = 1'b1;
        reg_mask[CFG_OUT_WIDTH] = 1'b1;
        reg_vals[CFG_TAP_ZERO]  = 16'h7FFF;
        reg_vals[CFG_TAP_COUNT] = 16'h0000;
        reg_vals[CFG_ROW_WIDTH] = 16'hFFFF;
        reg_vals[CFG_OUT_WIDTH] = 16'd1024;
        program_regs(reg_vals, reg_mask);
        @(posedge i_clk);
        for (k = 0; k < MAX_ROW_WIDTH + 2; k++) queue_pixel(rand_pixel(), k == MAX_ROW_WIDTH + 1);
        drain();

        // Random phases: new register settings, then a few frames of small rows
        while (items_queued < ITEM_TARGET) begin
            reg_mask = 8'($urandom);
            for (k = 0; k < MAX_TAPS; k++) begin
                reg_vals[k] = ($urandom_range(0, 3) == 0) ? (($urandom_range(0, 1) == 0) ?
                              16'h8000 : 16'h7FFF) : 16'($urandom);
            end
            pick = $urandom_range(0, 11);
            reg_vals[CFG_TAP_COUNT] = (pick == 0) ? 16'd0 :
                                      (pick == 1) ? 16'($urandom_range(6, 7)) :
                                      16'($urandom_range(1, 5));
            if ($urandom_range(0, 3) == 0) reg_vals[CFG_TAP_COUNT][15:3] = 13'($urandom);
            pick = $urandom_range(0, 15);
            reg_vals[CFG_ROW_WIDTH] = (pick == 0) ? 16'd0 :
                                      (pick == 1) ? 16'($urandom_range(13, 40)) :
                                      16'($urandom_range(1, 12));
            if ($urandom_range(0, 3) == 0) reg_vals[CFG_ROW_WIDTH][15:11] = 5'($urandom);
            // A frame in progress may only get narrower rows
            if (frame_open && clamp_row(reg_vals[CFG_ROW_WIDTH][10:0]) > clamp_row(row_w))
                reg_mask[CFG_ROW_WIDTH] = 1'b0;
            cur_rw = reg_mask[CFG_ROW_WIDTH] ? clamp_row(reg_vals[CFG_ROW_WIDTH][10:0]) :
                                               clamp_row(row_w);
            pick = $urandom_range(0, 11);
            reg_vals[CFG_OUT_WIDTH] = (pick == 0) ? 16'd0 :
                                      (pick == 1) ? 16'h07FF :
                                      16'($urandom_range(1, cur_rw + 2));
            if ($urandom_range(0, 3) == 0) reg_vals[CFG_OUT_WIDTH][15:11] = 5'($urandom);
            program_regs(reg_vals, reg_mask);

            @(posedge i_clk);
            // Close a frame left open, or carry on with it
            if (frame_open && $urandom_range(0, 1) == 0) queue_pixel(rand_pixel(), 1'b1);
            n_frames = $urandom_range(1, 3);
            for (f = 0; f < n_frames; f++) begin
                rows = active_taps() - 1 + $urandom_range(1, 3);
                len = rows * clamp_row(row_w);
                pick = $urandom_range(0, 9);
                shape = (pick < 3) ? t_frame_shape'(pick) : SHAPE_FULL;
                if (shape == SHAPE_NOISE) begin
                    for (k = 0; k < len; k++) queue_pixel(rand_pixel(), $urandom_range(0, 15) == 0);
                end else begin
                    if (shape == SHAPE_CUT) len = $urandom_range(1, len);
                    for (k = 0; k < len; k++) begin
                        queue_pixel(rand_pixel(),
                                    k == len - 1 && !(shape == SHAPE_OPEN && f == n_frames - 1));
                    end
                end
            end
            drain();
        end

        if (mismatch_cnt == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/vfc_pkg.sv
rtl/vfc_ram.sv
rtl/vfc_window.sv
rtl/vfc_mac.sv
rtl/vertical_fir_column_filter.sv
bench/tb_vertical_fir_column_filter.sv
